// File: src/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotator.
// No dependencies; used by qvr_qmul_left, qvr_qmul_right and the top level.
package qvr_pkg;

    localparam int QFRAC   = 14;    // fraction bits of a quaternion component
    localparam int QW      = 16;    // quaternion component width
    localparam int VW      = 32;    // vector component width
    localparam int P1W     = QW + VW;          // q * v product
    localparam int S1W     = P1W + 2;          // sum of three products
    localparam int TW      = S1W - QFRAC;      // intermediate quaternion component
    localparam int P2W     = TW + QW;          // t * q product
    localparam int S2W     = P2W + 2;          // sum of four products
    localparam int RW      = S2W - QFRAC;      // result before saturation

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] z;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] x;
    } t_quat;

    typedef struct packed {
        logic signed [VW-1:0] z;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] x;
    } t_vec;

    typedef struct packed {
        logic signed [TW-1:0] w;
        logic signed [TW-1:0] z;
        logic signed [TW-1:0] y;
        logic signed [TW-1:0] x;
    } t_tquat;

endpackage

// File: src/qvr_qmul_left.sv
// Left product t = q * (v,0): multiplier rank plus adder/shift rank.
// Depends on qvr_pkg.
module qvr_qmul_left (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qvr_pkg::t_quat i_quat,
    input  qvr_pkg::t_vec  i_vec,
    output logic           o_valid,
    input  logic           i_ready,
    output qvr_pkg::t_tquat o_t,
    output qvr_pkg::t_quat o_quat
);

    localparam int P1W = qvr_pkg::P1W;
    localparam int S1W = qvr_pkg::S1W;

    // stage A: products
    logic                  r_va;
    qvr_pkg::t_quat        r_qa;
    logic signed [P1W-1:0] r_wvx, r_yvz, r_zvy;
    logic signed [P1W-1:0] r_wvy, r_xvz, r_zvx;
    logic signed [P1W-1:0] r_wvz, r_xvy, r_yvx;
    logic signed [P1W-1:0] r_xvx, r_yvy, r_zvz;

    // stage B: sums, shifted
    logic                  r_vb;
    qvr_pkg::t_quat        r_qb;
    qvr_pkg::t_tquat       r_t;

    logic                  en_a, en_b;
    logic signed [S1W-1:0] n_sx, n_sy, n_sz, n_sw;
    qvr_pkg::t_tquat       n_t;

    assign en_b    = !r_vb || i_ready;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en_a) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_qa  <= i_quat;
            r_wvx <= $signed(i_quat.w) * $signed(i_vec.x);
            r_yvz <= $signed(i_quat.y) * $signed(i_vec.z);
            r_zvy <= $signed(i_quat.z) * $signed(i_vec.y);
            r_wvy <= $signed(i_quat.w) * $signed(i_vec.y);
            r_xvz <= $signed(i_quat.x) * $signed(i_vec.z);
            r_zvx <= $signed(i_quat.z) * $signed(i_vec.x);
            r_wvz <= $signed(i_quat.w) * $signed(i_vec.z);
            r_xvy <= $signed(i_quat.x) * $signed(i_vec.y);
            r_yvx <= $signed(i_quat.y) * $signed(i_vec.x);
            r_xvx <= $signed(i_quat.x) * $signed(i_vec.x);
            r_yvy <= $signed(i_quat.y) * $signed(i_vec.y);
            r_zvz <= $signed(i_quat.z) * $signed(i_vec.z);
        end
    end

    always_comb begin
        n_sx = S1W'(r_wvx) + S1W'(r_yvz) - S1W'(r_zvy);
        n_sy = S1W'(r_wvy) - S1W'(r_xvz) + S1W'(r_zvx);
        n_sz = S1W'(r_wvz) + S1W'(r_xvy) - S1W'(r_yvx);
        n_sw = -S1W'(r_xvx) - S1W'(r_yvy) - S1W'(r_zvz);
        // arithmetic shift right = floor, taken as a part-select
        n_t.x = n_sx[S1W-1:qvr_pkg::QFRAC];
        n_t.y = n_sy[S1W-1:qvr_pkg::QFRAC];
        n_t.z = n_sz[S1W-1:qvr_pkg::QFRAC];
        n_t.w = n_sw[S1W-1:qvr_pkg::QFRAC];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_qb <= r_qa;
            r_t  <= n_t;
        end
    end

    assign o_valid = r_vb;
    assign o_t     = r_t;
    assign o_quat  = r_qb;

endmodule

// File: src/qvr_qmul_right.sv
// Right product r = t * conj(q), shift and 32-bit saturation.
// Depends on qvr_pkg.
module qvr_qmul_right (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qvr_pkg::t_tquat i_t,
    input  qvr_pkg::t_quat  i_quat,
    output logic            o_valid,
    input  logic            i_ready,
    output qvr_pkg::t_vec   o_vec,
    output logic            o_sat
);

    localparam int P2W = qvr_pkg::P2W;
    localparam int S2W = qvr_pkg::S2W;
    localparam int RW  = qvr_pkg::RW;
    localparam int VW  = qvr_pkg::VW;

    // stage C: products
    logic                  r_vc;
    logic signed [P2W-1:0] r_txw, r_twx, r_tyz, r_tzy;
    logic signed [P2W-1:0] r_tyw, r_twy, r_txz, r_tzx;
    logic signed [P2W-1:0] r_tzw, r_twz, r_txy, r_tyx;

    // stage D: sums, shift, clamp
    logic                  r_vd;
    qvr_pkg::t_vec         r_vec;
    logic                  r_sat;

    logic                  en_c, en_d;
    logic signed [S2W-1:0] n_sx, n_sy, n_sz;
    logic        [VW-1:0]  n_x, n_y, n_z;
    logic                  n_fx, n_fy, n_fz;

    // clamp a shifted sum to the signed output range; flag in the top bit
    function automatic logic [VW:0] sat_vw(input logic [RW-1:0] a);
        logic [VW:0] res;
        if (a[RW-1:VW-1] == '0 || a[RW-1:VW-1] == '1) begin
            res = {1'b0, a[VW-1:0]};
        end else if (a[RW-1]) begin
            res = {1'b1, 1'b1, {(VW-1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(VW-1){1'b1}}};
        end
        return res;
    endfunction

    assign en_d    = !r_vd || i_ready;
    assign en_c    = !r_vc || en_d;
    assign o_ready = en_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (en_c) begin
            r_vc <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_txw <= $signed(i_t.x) * $signed(i_quat.w);
            r_twx <= $signed(i_t.w) * $signed(i_quat.x);
            r_tyz <= $signed(i_t.y) * $signed(i_quat.z);
            r_tzy <= $signed(i_t.z) * $signed(i_quat.y);
            r_tyw <= $signed(i_t.y) * $signed(i_quat.w);
            r_twy <= $signed(i_t.w) * $signed(i_quat.y);
            r_txz <= $signed(i_t.x) * $signed(i_quat.z);
            r_tzx <= $signed(i_t.z) * $signed(i_quat.x);
            r_tzw <= $signed(i_t.z) * $signed(i_quat.w);
            r_twz <= $signed(i_t.w) * $signed(i_quat.z);
            r_txy <= $signed(i_t.x) * $signed(i_quat.y);
            r_tyx <= $signed(i_t.y) * $signed(i_quat.x);
        end
    end

    always_comb begin
        n_sx = S2W'(r_txw) - S2W'(r_twx) - S2W'(r_tyz) + S2W'(r_tzy);
        n_sy = S2W'(r_tyw) - S2W'(r_twy) + S2W'(r_txz) - S2W'(r_tzx);
        n_sz = S2W'(r_tzw) - S2W'(r_twz) - S2W'(r_txy) + S2W'(r_tyx);
        {n_fx, n_x} = sat_vw(n_sx[S2W-1:qvr_pkg::QFRAC]);
        {n_fy, n_y} = sat_vw(n_sy[S2W-1:qvr_pkg::QFRAC]);
        {n_fz, n_z} = sat_vw(n_sz[S2W-1:qvr_pkg::QFRAC]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (en_d) begin
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_vec.x <= n_x;
            r_vec.y <= n_y;
            r_vec.z <= n_z;
            r_sat   <= n_fx | n_fy | n_fz;
        end
    end

    assign o_valid = r_vd;
    assign o_vec   = r_vec;
    assign o_sat   = r_sat;

endmodule

// File: src/quaternion_vector_rotate.sv
// Throughput: one item per cycle while the master side keeps accepting; four register
//   stages (two multiplier ranks, two adder ranks), each with its own valid bit.
// Stalls: a stage loads whenever it is empty or the stage after it moves on.
// Reset: synchronous, active low; clears the valid bits, data regs are not reset.
//
// Top level of the quaternion vector rotator: r = q * (v,0) * conj(q), vector
// part returned, Q16.16 saturated. Depends on qvr_pkg, qvr_qmul_left and
// qvr_qmul_right.
module quaternion_vector_rotate (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // i_s_tdata: quat_x[15:0] quat_y[31:16] quat_z[47:32] quat_w[63:48]
    //            vec_x[95:64] vec_y[127:96] vec_z[159:128]
    input  logic [159:0] i_s_tdata,
    // master side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // o_m_tdata: out_x[31:0] out_y[63:32] out_z[95:64]
    output logic [95:0]  o_m_tdata,
    // o_m_tuser: saturated[0]
    output logic [0:0]   o_m_tuser
);

    qvr_pkg::t_quat  in_quat;
    qvr_pkg::t_vec   in_vec;
    qvr_pkg::t_tquat mid_t;
    qvr_pkg::t_quat  mid_quat;
    logic            mid_valid;
    logic            mid_ready;
    qvr_pkg::t_vec   out_vec;
    logic            out_sat;

    // unpack the slave payload
    assign in_quat.x = i_s_tdata[15:0];
    assign in_quat.y = i_s_tdata[31:16];
    assign in_quat.z = i_s_tdata[47:32];
    assign in_quat.w = i_s_tdata[63:48];
    assign in_vec.x  = i_s_tdata[95:64];
    assign in_vec.y  = i_s_tdata[127:96];
    assign in_vec.z  = i_s_tdata[159:128];

    // t = q * (v,0), floor shift by the quaternion fraction
    qvr_qmul_left u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_quat  (in_quat),
        .i_vec   (in_vec),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_t     (mid_t),
        .o_quat  (mid_quat)
    );

    // r = t * conj(q), floor shift, clamp to 32 bits; the last stage is the
    // output register, so the ready chain only stalls on a held result
    qvr_qmul_right u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_t     (mid_t),
        .i_quat  (mid_quat),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_vec   (out_vec),
        .o_sat   (out_sat)
    );

    assign o_m_tdata = {out_vec.z, out_vec.y, out_vec.x};
    assign o_m_tuser = out_sat;

endmodule

// File: src/qvr_checker.sv
// Port-level checks for quaternion_vector_rotate, attached by bind.
// Depends on the top level's port list only.
module qvr_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         o_s_tready,
    input  logic [159:0] i_s_tdata,
    input  logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  logic [95:0]  o_m_tdata,
    input  logic [0:0]   o_m_tuser
);

    logic unused_in;
    assign unused_in = i_s_tvalid ^ (^i_s_tdata);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // a held result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // nothing held at the output means nothing can block the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // the clamp flag only goes with a component at a range limit
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            o_m_tdata[31:0]  == 32'h7fff_ffff || o_m_tdata[31:0]  == 32'h8000_0000 ||
            o_m_tdata[63:32] == 32'h7fff_ffff || o_m_tdata[63:32] == 32'h8000_0000 ||
            o_m_tdata[95:64] == 32'h7fff_ffff || o_m_tdata[95:64] == 32'h8000_0000)
        else $error("saturated flag without a clamped component");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: tb/sv/tb.sv
// Self-checking bench for quaternion_vector_rotate: drives q and v items over the
// slave stream, predicts each rotated vector in fixed point and checks the master stream.
// Depends on qvr_pkg and quaternion_vector_rotate.
module tb;

    // one input transfer: quaternion and vector, packed as on i_s_tdata
    typedef struct packed {
        qvr_pkg::t_vec  v;
        qvr_pkg::t_quat q;
    } t_rot_item;

    // one rotated vector as it should leave the block
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } t_rot_result;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;   // quat x,y,z,w then vec x,y,z, from bit 0 up
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;        // out_x, out_y, out_z, from bit 0 up
    logic [0:0]   m_tuser;        // saturated

    t_rot_item   pending_items[$];    // waiting to be offered by the driver
    t_rot_result rotations_due[$];    // predicted results, oldest first
    t_rot_item   offered;             // item currently on the slave side

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_req = 1'b0;
    int  hold_left = 0;

    int  err_count = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  n_clamped = 0;

    quaternion_vector_rotate dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // clamp to signed 32 bits and note when the clamp bites
    function automatic logic [31:0] clamp32(input longint a, inout logic hit);
        if (a > 64'sd2147483647) begin
            hit = 1'b1;
            return 32'h7fff_ffff;
        end else if (a < -64'sd2147483648) begin
            hit = 1'b1;
            return 32'h8000_0000;
        end
        return a[31:0];
    endfunction

    // r = q * (v,0) * conj(q), vector part; both stages floor-shift by QFRAC.
    // Stage-two sums stay under 2^52, so 64-bit signed math is exact.
    function automatic t_rot_result rotate_vector(input t_rot_item it);
        longint qx, qy, qz, qw, vx, vy, vz;
        longint tx, ty, tz, tw, rx, ry, rz;
        t_rot_result r;
        qx = $signed(it.q.x);  qy = $signed(it.q.y);
        qz = $signed(it.q.z);  qw = $signed(it.q.w);
        vx = $signed(it.v.x);  vy = $signed(it.v.y);  vz = $signed(it.v.z);
        tx = (qw * vx + qy * vz - qz * vy) >>> qvr_pkg::QFRAC;
        ty = (qw * vy - qx * vz + qz * vx) >>> qvr_pkg::QFRAC;
        tz = (qw * vz + qx * vy - qy * vx) >>> qvr_pkg::QFRAC;
        tw = (-(qx * vx) - qy * vy - qz * vz) >>> qvr_pkg::QFRAC;
        rx = (tx * qw - tw * qx - ty * qz + tz * qy) >>> qvr_pkg::QFRAC;
        ry = (ty * qw - tw * qy + tx * qz - tz * qx) >>> qvr_pkg::QFRAC;
        rz = (tz * qw - tw * qz - tx * qy + ty * qx) >>> qvr_pkg::QFRAC;
        r.sat = 1'b0;
        r.x = clamp32(rx, r.sat);
        r.y = clamp32(ry, r.sat);
        r.z = clamp32(rz, r.sat);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pending items, holds an item until its transfer
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                rotations_due.push_back(rotate_vector(offered));
                n_accepted++;
            end
            // a new decision only once the slot is free
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_items.pop_front();
                    s_tdata <= offered;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here; the stimulus only requests it
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
            hold_left <= 120;
    end

    // ------------------------------------------------------------------
    // Monitor: checks each master-side transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_rot_result exp_r;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (rotations_due.size() == 0) begin
                    $error("result with no pending expectation: x=%0d y=%0d z=%0d sat=%0d",
                           $signed(m_tdata[31:0]), $signed(m_tdata[63:32]),
                           $signed(m_tdata[95:64]), m_tuser[0]);
                    err_count++;
                end else begin
                    exp_r = rotations_due.pop_front();
                    n_checked++;
                    if (exp_r.sat)
                        n_clamped++;
                    if (m_tdata[31:0] !== exp_r.x) begin
                        $error("out_x mismatch: expected %0d, got %0d",
                               exp_r.x, $signed(m_tdata[31:0]));
                        err_count++;
                    end
                    if (m_tdata[63:32] !== exp_r.y) begin
                        $error("out_y mismatch: expected %0d, got %0d",
                               exp_r.y, $signed(m_tdata[63:32]));
                        err_count++;
                    end
                    if (m_tdata[95:64] !== exp_r.z) begin
                        $error("out_z mismatch: expected %0d, got %0d",
                               exp_r.z, $signed(m_tdata[95:64]));
                        err_count++;
                    end
                    if (m_tuser[0] !== exp_r.sat) begin
                        $error("saturated mismatch: expected %0d, got %0d",
                               exp_r.sat, m_tuser[0]);
                        err_count++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // corner values of a Q2.14 component, or a random one
    function automatic logic [15:0] quat_pick();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'sh4000;            // 1.0
            4: return 16'shc000;            // -1.0
            5: return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // corner values of a Q16.16 component, or a random one
    function automatic logic [31:0] vec_pick();
        case ($urandom_range(6))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0001_0000;        // 1.0
            default: return $urandom;
        endcase
    endfunction

    function automatic t_rot_item make_item(input logic [15:0] x, input logic [15:0] y,
                                            input logic [15:0] z, input logic [15:0] w,
                                            input logic [31:0] vx, input logic [31:0] vy,
                                            input logic [31:0] vz);
        t_rot_item it;
        it.q.x = x;  it.q.y = y;  it.q.z = z;  it.q.w = w;
        it.v.x = vx; it.v.y = vy; it.v.z = vz;
        return it;
    endfunction

    // random item: half are quaternions with components in [-1.0, 1.0] and moderate
    // vectors, the rest raw bits and corner mixes that push into saturation
    function automatic t_rot_item random_item();
        t_rot_item it;
        int kind;
        kind = $urandom_range(9);
        if (kind < 5) begin
            it.q.x = 16'($urandom_range(32768) - 16384);
            it.q.y = 16'($urandom_range(32768) - 16384);
            it.q.z = 16'($urandom_range(32768) - 16384);
            it.q.w = 16'($urandom_range(32768) - 16384);
            it.v.x = $signed($urandom) >>> $urandom_range(16);
            it.v.y = $signed($urandom) >>> $urandom_range(16);
            it.v.z = $signed($urandom) >>> $urandom_range(16);
        end else if (kind < 8) begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            it = make_item(quat_pick(), quat_pick(), quat_pick(), quat_pick(),
                           vec_pick(), vec_pick(), vec_pick());
        end
        return it;
    endfunction

    // sender pause: nothing offered until every prediction is matched
    task automatic drain();
        while (pending_items.size() > 0 || rotations_due.size() > 0 || s_tvalid)
            @(posedge clk);
    endtask

    initial begin
        int n_items;
        n_items = 160;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, zero quaternion, half turns, a quarter turn
        // about z, non-unit scaling, and corners that saturate
        pending_items.push_back(make_item(16'h0000, 16'h0000, 16'h0000, 16'h4000,
                                          32'h0001_0000, 32'h0002_0000, 32'hfffd_0000));
        pending_items.push_back(make_item(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        pending_items.push_back(make_item(16'h4000, 16'h0000, 16'h0000, 16'h0000,
                                          32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        pending_items.push_back(make_item(16'h0000, 16'h4000, 16'h0000, 16'h0000,
                                          32'h0003_0000, 32'hffff_0000, 32'h0002_0000));
        pending_items.push_back(make_item(16'h0000, 16'h0000, 16'h4000, 16'h0000,
                                          32'h1234_5678, 32'h8765_4321, 32'h0000_0001));
        pending_items.push_back(make_item(16'h0000, 16'h0000, 16'h2d41, 16'h2d41,
                                          32'h0001_0000, 32'h0000_0000, 32'h0000_0000));
        pending_items.push_back(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_items.push_back(make_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_items.push_back(make_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                                          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        pending_items.push_back(make_item(16'h0000, 16'h0000, 16'h0000, 16'h8000,
                                          32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001));
        // twice unit length: result scales by four
        pending_items.push_back(make_item(16'h0000, 16'h0000, 16'h0000, 16'h8000,
                                          32'h0001_0000, 32'hffff_0000, 32'h0000_8000));
        pending_items.push_back(make_item(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        pending_items.push_back(make_item(16'h0001, 16'h0001, 16'h0001, 16'h0001,
                                          32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        pending_items.push_back(make_item(16'h2000, 16'he000, 16'h2000, 16'h2000,
                                          32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff));
        drain();

        // phase 0: no idling, plus a long receiver hold-off while the
        // sender keeps offering, so the pipeline fills and backs up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (n_items) pending_items.push_back(random_item());
        repeat (4) @(posedge clk);
        hold_req <= 1'b1;
        while (hold_left == 0) @(posedge clk);
        hold_req <= 1'b0;
        drain();

        // phase 1: sender idle about half the time
        send_idle_pct = 54;
        recv_stall_pct = 0;
        repeat (n_items) pending_items.push_back(random_item());
        drain();

        // phase 2: receiver stalling about half the time
        send_idle_pct = 0;
        recv_stall_pct = 54;
        repeat (n_items) pending_items.push_back(random_item());
        drain();

        // phase 3: light gaps on both sides
        send_idle_pct = 15;
        recv_stall_pct = 15;
        repeat (n_items) pending_items.push_back(random_item());
        drain();

        // give the pipeline a margin before the final check
        repeat (12) @(posedge clk);

        if (rotations_due.size() != 0) begin
            $error("%0d predicted results never arrived", rotations_due.size());
            err_count++;
        end

        $display("summary: %0d items rotated, %0d results checked, %0d of them clamped",
                 n_accepted, n_checked, n_clamped);
        $display("summary: idle/stall phases plus a long output hold-off and drained pauses");
        if (err_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// File: quaternion_vector_rotate.f
src/qvr_pkg.sv
src/qvr_qmul_left.sv
src/qvr_qmul_right.sv
src/quaternion_vector_rotate.sv
src/qvr_checker.sv
tb/sv/tb.sv
